>>> design/i2cms_pkg.sv
// Shared types and constants of the I2C master byte sequencer.
// Used by the front end, the phase generator and the top level.
`default_nettype none

package i2cms_pkg;

  // Command codes carried on in_command
  typedef enum logic [2:0] {
    CMD_START  = 3'd0,
    CMD_STOP   = 3'd1,
    CMD_ADDR   = 3'd2,
    CMD_WRITE  = 3'd3,
    CMD_READ   = 3'd4,
    CMD_SAMPLE = 3'd5
  } cmd_t;

  // Operation left open by the last command
  typedef enum logic [1:0] {
    OP_IDLE = 2'd0,
    OP_ACK  = 2'd1,
    OP_READ = 2'd2
  } op_t;

  // Kinds of phase sequence handed from front end to back end
  typedef enum logic [2:0] {
    JOB_START = 3'd0,
    JOB_STOP  = 3'd1,
    JOB_SEND  = 3'd2,
    JOB_READ  = 3'd3,
    JOB_ACK   = 3'd4,
    JOB_RDBIT = 3'd5,
    JOB_RDEND = 3'd6
  } job_kind_t;

  // One classified command: byte to send or received byte, plus one flag
  // (sampled ack level, or SDA level of the ninth read bit)
  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] data;
    logic       flag;
  } job_t;

  localparam int          QUEUE_DEPTH_DEF = 2;
  localparam logic [3:0]  READ_BITS       = 4'h8;
  localparam logic [4:0]  SEND_PHASES     = 5'd17;

endpackage

`default_nettype wire

>>> design/i2c_master_byte_sequencer_unit.sv
// I2C master byte sequencer: turns start, stop, address, write, read and
// line sample commands into open-drain bus phases, one result per phase.
// A command is taken whenever the job queue has room; the phase generator
// then emits one phase per cycle unless out_stall holds the output, and each
// command gives this many phases: start 4, stop 3, address or write 17,
// read 1, ack sample 1, read sample 2 (or 4 on the eighth bit). The phase
// generator sets the sustained rate; the queue (QUEUE_DEPTH jobs) lets new
// commands be classified while earlier phases still wait on out_stall.
// Line samples while idle and unused command codes are taken and give no
// phase. Depends on i2cms_pkg, i2cms_front, i2cms_fifo and i2cms_back.
`default_nettype none

module i2c_master_byte_sequencer_unit #(
  parameter int QUEUE_DEPTH = i2cms_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [6:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_command,
  input  wire logic [7:0]  in_tx_byte,
  input  wire logic        in_read_not_write,
  input  wire logic        in_send_ack,
  input  wire logic        in_sda_level,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_scl_release,
  output logic             out_sda_release,
  output logic             out_sample_now,
  output logic [7:0]       out_rx_byte,
  output logic             out_rx_valid,
  output logic             out_nack,
  output logic             out_last
);

  localparam int JOB_W = $bits(i2cms_pkg::job_t);

  logic             q_full, q_empty, q_push, q_pop;
  i2cms_pkg::job_t  push_job, head_job;
  logic [JOB_W-1:0] head_bits;

  assign in_stall = q_full;
  assign head_job = i2cms_pkg::job_t'(head_bits);

  // Classify commands
  i2cms_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .queue_full        (q_full),
    .in_command        (in_command),
    .in_tx_byte        (in_tx_byte),
    .in_read_not_write (in_read_not_write),
    .in_send_ack       (in_send_ack),
    .in_sda_level      (in_sda_level),
    .push              (q_push),
    .push_job          (push_job)
  );

  // Queue jobs between the two sides
  i2cms_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_job),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (head_bits)
  );

  // Unfold jobs into bus phases
  i2cms_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_avail       (~q_empty),
    .job             (head_job),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_scl_release (out_scl_release),
    .out_sda_release (out_sda_release),
    .out_sample_now  (out_sample_now),
    .out_rx_byte     (out_rx_byte),
    .out_rx_valid    (out_rx_valid),
    .out_nack        (out_nack),
    .out_last        (out_last)
  );

  // A received byte and a nack only ever close a command
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_rx_valid || out_nack) |-> out_last && !out_scl_release)
    else $error("rx_valid or nack on a phase that does not close a command");

  // A sample request always releases both lines and ends the command
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sample_now |-> out_scl_release && out_sda_release && out_last)
    else $error("sample request with a line driven low or not last");

  // No phase comes out in the cycle after reset
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid straight after reset");

  // A job is only dropped when a phase is loaded
  assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_valid && out_last)
    else $error("job dropped without its last phase");

endmodule

`default_nettype wire

>>> design/i2cms_front.sv
// Front end: accepts commands, keeps the read/ack state and classifies
// each command into a job for the queue. Depends on i2cms_pkg.
`default_nettype none

module i2cms_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_wr_en,
  input  wire logic [6:0]      cfg_wr_data,
  input  wire logic            in_valid,
  input  wire logic            queue_full,
  input  wire logic [2:0]      in_command,
  input  wire logic [7:0]      in_tx_byte,
  input  wire logic            in_read_not_write,
  input  wire logic            in_send_ack,
  input  wire logic            in_sda_level,
  output logic                 push,
  output i2cms_pkg::job_t      push_job
);

  logic [6:0]         addr_r;
  logic [7:0]         sr_r, sr_nxt;
  logic [3:0]         bc_r, bc_nxt;
  logic               ack_r, ack_nxt;
  i2cms_pkg::op_t     pend_r, pend_nxt;
  logic               accept;
  logic [7:0]         sr_shift;
  logic [3:0]         bc_inc;
  i2cms_pkg::cmd_t    cmd;

  assign accept   = in_valid & ~queue_full;
  assign cmd      = i2cms_pkg::cmd_t'(in_command);
  assign sr_shift = {sr_r[6:0], in_sda_level};
  assign bc_inc   = bc_r + 4'd1;

  // Hold the target address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
    end else if (cfg_wr_en) begin
      addr_r <= cfg_wr_data;
    end
  end

  // Register the pending operation and read state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= i2cms_pkg::OP_IDLE;
      sr_r   <= '0;
      bc_r   <= '0;
      ack_r  <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      sr_r   <= sr_nxt;
      bc_r   <= bc_nxt;
      ack_r  <= ack_nxt;
    end
  end

  // Next pending operation
  always_comb begin
    pend_nxt = pend_r;
    if (accept) begin
      case (cmd)
        i2cms_pkg::CMD_START,
        i2cms_pkg::CMD_STOP:  pend_nxt = i2cms_pkg::OP_IDLE;
        i2cms_pkg::CMD_ADDR,
        i2cms_pkg::CMD_WRITE: pend_nxt = i2cms_pkg::OP_ACK;
        i2cms_pkg::CMD_READ:  pend_nxt = i2cms_pkg::OP_READ;
        i2cms_pkg::CMD_SAMPLE: begin
          case (pend_r)
            i2cms_pkg::OP_ACK: pend_nxt = i2cms_pkg::OP_IDLE;
            i2cms_pkg::OP_READ: begin
              if (bc_inc == i2cms_pkg::READ_BITS) pend_nxt = i2cms_pkg::OP_IDLE;
            end
            default: pend_nxt = pend_r;
          endcase
        end
        default: pend_nxt = pend_r;
      endcase
    end
  end

  // Classify the command and update the shift state
  always_comb begin
    push          = 1'b0;
    push_job.kind = i2cms_pkg::JOB_START;
    push_job.data = '0;
    push_job.flag = 1'b0;
    sr_nxt        = sr_r;
    bc_nxt        = bc_r;
    ack_nxt       = ack_r;
    if (accept) begin
      case (cmd)
        i2cms_pkg::CMD_START: begin
          push = 1'b1;
        end
        i2cms_pkg::CMD_STOP: begin
          push          = 1'b1;
          push_job.kind = i2cms_pkg::JOB_STOP;
        end
        i2cms_pkg::CMD_ADDR: begin
          push          = 1'b1;
          push_job.kind = i2cms_pkg::JOB_SEND;
          push_job.data = {addr_r, in_read_not_write};
        end
        i2cms_pkg::CMD_WRITE: begin
          push          = 1'b1;
          push_job.kind = i2cms_pkg::JOB_SEND;
          push_job.data = in_tx_byte;
        end
        i2cms_pkg::CMD_READ: begin
          push          = 1'b1;
          push_job.kind = i2cms_pkg::JOB_READ;
          sr_nxt        = '0;
          bc_nxt        = '0;
          ack_nxt       = in_send_ack;
        end
        i2cms_pkg::CMD_SAMPLE: begin
          case (pend_r)
            i2cms_pkg::OP_ACK: begin
              push          = 1'b1;
              push_job.kind = i2cms_pkg::JOB_ACK;
              push_job.flag = in_sda_level;
            end
            i2cms_pkg::OP_READ: begin
              push   = 1'b1;
              sr_nxt = sr_shift;
              if (bc_inc == i2cms_pkg::READ_BITS) begin
                push_job.kind = i2cms_pkg::JOB_RDEND;
                push_job.data = sr_shift;
                push_job.flag = ~ack_r;
                bc_nxt        = '0;
              end else begin
                push_job.kind = i2cms_pkg::JOB_RDBIT;
                bc_nxt        = bc_inc;
              end
            end
            default: push = 1'b0;
          endcase
        end
        default: push = 1'b0;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/i2cms_fifo.sv
// Short job queue between front end and back end, held in flip-flops.
// Generic in width and depth; no package dependency.
`default_nettype none

module i2cms_fifo #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic                  full,
  output logic                  empty,
  output logic [WIDTH-1:0]      head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    cnt_r;

  assign full  = (cnt_r == FULL_CNT);
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> design/i2cms_back.sv
// Back end: unfolds the job at the queue head into bus phases, one per
// cycle unless out_stall holds the output, into the output register. Depends on i2cms_pkg.
`default_nettype none

module i2cms_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             job_avail,
  input  wire i2cms_pkg::job_t  job,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  out_scl_release,
  output logic                  out_sda_release,
  output logic                  out_sample_now,
  output logic [7:0]            out_rx_byte,
  output logic                  out_rx_valid,
  output logic                  out_nack,
  output logic                  out_last
);

  logic [4:0] idx_r;
  logic       valid_r;
  logic       scl_r, sda_r, smp_r, rxv_r, nack_r, last_r;
  logic [7:0] rx_r;
  logic       adv;
  logic       p_scl, p_sda, p_smp, p_rxv, p_nack, p_last;
  logic [7:0] p_rx;
  logic [4:0] last_idx;
  logic [2:0] bit_sel;

  assign adv     = ~valid_r | ~out_stall;
  assign p_last  = (idx_r == last_idx);
  assign pop     = adv & job_avail & p_last;
  assign bit_sel = 3'd7 - idx_r[3:1];

  // Work out the phase at the current index of the head job
  always_comb begin
    p_scl    = 1'b0;
    p_sda    = 1'b1;
    p_smp    = 1'b0;
    p_rxv    = 1'b0;
    p_nack   = 1'b0;
    p_rx     = '0;
    last_idx = '0;
    case (job.kind)
      i2cms_pkg::JOB_START: begin
        last_idx = 5'd3;
        p_scl    = (idx_r == 5'd1) || (idx_r == 5'd2);
        p_sda    = (idx_r == 5'd0) || (idx_r == 5'd1);
      end
      i2cms_pkg::JOB_STOP: begin
        last_idx = 5'd2;
        p_scl    = (idx_r != 5'd0);
        p_sda    = (idx_r == 5'd2);
      end
      i2cms_pkg::JOB_SEND: begin
        last_idx = i2cms_pkg::SEND_PHASES - 5'd1;
        if (idx_r == last_idx) begin
          p_scl = 1'b1;
          p_sda = 1'b1;
          p_smp = 1'b1;
        end else begin
          p_scl = ~idx_r[0];
          p_sda = job.data[bit_sel];
        end
      end
      i2cms_pkg::JOB_READ: begin
        p_scl = 1'b1;
        p_smp = 1'b1;
      end
      i2cms_pkg::JOB_ACK: begin
        p_nack = job.flag;
      end
      i2cms_pkg::JOB_RDBIT: begin
        last_idx = 5'd1;
        p_scl    = (idx_r == 5'd1);
        p_smp    = (idx_r == 5'd1);
      end
      i2cms_pkg::JOB_RDEND: begin
        last_idx = 5'd3;
        p_scl    = (idx_r == 5'd1);
        p_sda    = ((idx_r == 5'd1) || (idx_r == 5'd2)) ? job.flag : 1'b1;
        if (idx_r == 5'd3) begin
          p_rx  = job.data;
          p_rxv = 1'b1;
        end
      end
      default: last_idx = '0;
    endcase
  end

  // Step through phases and drop the job after its last one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (adv) begin
      valid_r <= job_avail;
      if (job_avail) begin
        idx_r <= p_last ? '0 : idx_r + 5'd1;
      end
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (adv && job_avail) begin
      scl_r  <= p_scl;
      sda_r  <= p_sda;
      smp_r  <= p_smp;
      rx_r   <= p_rx;
      rxv_r  <= p_rxv;
      nack_r <= p_nack;
      last_r <= p_last;
    end
  end

  assign out_valid       = valid_r;
  assign out_scl_release = scl_r;
  assign out_sda_release = sda_r;
  assign out_sample_now  = smp_r;
  assign out_rx_byte     = rx_r;
  assign out_rx_valid    = rxv_r;
  assign out_nack        = nack_r;
  assign out_last        = last_r;

endmodule

`default_nettype wire

>>> tb/sv/tb_i2c_master_byte_sequencer_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for i2c_master_byte_sequencer_unit: predicts the bus phases
// of every command and checks them against the result channel. Depends on i2cms_pkg.

module tb_i2c_master_byte_sequencer_unit;

  // Codes that the sequencer must take and ignore
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS = 160;

  typedef struct packed {
    logic       scl_rel;
    logic       sda_rel;
    logic       smp;
    logic [7:0] rx_data;
    logic       rx_done;
    logic       nack_seen;
    logic       is_last;
  } bus_phase_t;

  // Phase predictor and store of expected phases
  class phase_scoreboard;
    bus_phase_t       expected_q[$];
    logic [6:0]       target_addr;
    logic [7:0]       rx_shift;
    logic [3:0]       rx_bits;
    i2cms_pkg::op_t   open_op;
    logic             ack_sel;
    int               errors;
    int               checked;
    int               bytes_read;
    int               nacks;
    int               printed;

    function new();
      target_addr = '0;
      rx_shift    = '0;
      rx_bits     = '0;
      open_op     = i2cms_pkg::OP_IDLE;
      ack_sel     = 1'b0;
    endfunction

    function void set_address(logic [6:0] addr);
      target_addr = addr;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void add_phase(logic scl, logic sda, logic smp, logic [7:0] rx, logic rxv,
                            logic nk, logic lst);
      bus_phase_t p;
      p = '{scl, sda, smp, rx, rxv, nk, lst};
      expected_q.push_back(p);
    endfunction

    // Eight data bits MSB first, each as SCL high then low, then the ack slot
    function void add_byte(logic [7:0] value);
      for (int i = 7; i >= 0; i--) begin
        add_phase(1'b1, value[i], 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
        add_phase(1'b0, value[i], 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
      end
      add_phase(1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 1'b1);
      open_op = i2cms_pkg::OP_ACK;
    endfunction

    // Advance the model by one accepted command; return the number of phases it adds
    function int note_command(logic [2:0] cmd, logic [7:0] tx, logic rnw, logic ack,
                              logic lvl);
      int depth0;
      logic nine;
      depth0 = expected_q.size();
      case (cmd)
        i2cms_pkg::CMD_START: begin
          open_op = i2cms_pkg::OP_IDLE;
          add_phase(1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
          add_phase(1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
          add_phase(1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
          add_phase(1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1);
        end
        i2cms_pkg::CMD_STOP: begin
          open_op = i2cms_pkg::OP_IDLE;
          add_phase(1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
          add_phase(1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
          add_phase(1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1);
        end
        i2cms_pkg::CMD_ADDR:  add_byte({target_addr, rnw});
        i2cms_pkg::CMD_WRITE: add_byte(tx);
        i2cms_pkg::CMD_READ: begin
          open_op  = i2cms_pkg::OP_READ;
          rx_shift = '0;
          rx_bits  = '0;
          ack_sel  = ack;
          add_phase(1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 1'b1);
        end
        i2cms_pkg::CMD_SAMPLE: begin
          if (open_op == i2cms_pkg::OP_ACK) begin
            open_op = i2cms_pkg::OP_IDLE;
            add_phase(1'b0, 1'b1, 1'b0, 8'h00, 1'b0, lvl, 1'b1);
          end else if (open_op == i2cms_pkg::OP_READ) begin
            rx_shift = {rx_shift[6:0], lvl};
            rx_bits  = rx_bits + 4'd1;
            add_phase(1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
            if (rx_bits < i2cms_pkg::READ_BITS) begin
              add_phase(1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 1'b1);
            end else begin
              // Ninth bit: drive SDA low for ack, release it for nack
              nine = ~ack_sel;
              add_phase(1'b1, nine, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
              add_phase(1'b0, nine, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
              add_phase(1'b0, 1'b1, 1'b0, rx_shift, 1'b1, 1'b0, 1'b1);
              open_op = i2cms_pkg::OP_IDLE;
              rx_bits = '0;
            end
          end
        end
        default: ;
      endcase
      return expected_q.size() - depth0;
    endfunction

    task report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      errors++;
      if (printed < 30) begin
        printed++;
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      end
    endtask

    // Compare one accepted phase with the oldest expectation
    task check_phase(bus_phase_t got);
      bus_phase_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("phase with nothing expected", 8'h00, 8'h00);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (want.rx_done) bytes_read++;
      if (want.nack_seen) nacks++;
      if (got.scl_rel !== want.scl_rel)
        report_mismatch("scl_release", {7'b0, got.scl_rel}, {7'b0, want.scl_rel});
      if (got.sda_rel !== want.sda_rel)
        report_mismatch("sda_release", {7'b0, got.sda_rel}, {7'b0, want.sda_rel});
      if (got.smp !== want.smp)
        report_mismatch("sample_now", {7'b0, got.smp}, {7'b0, want.smp});
      if (got.rx_data !== want.rx_data)
        report_mismatch("rx_byte", got.rx_data, want.rx_data);
      if (got.rx_done !== want.rx_done)
        report_mismatch("rx_valid", {7'b0, got.rx_done}, {7'b0, want.rx_done});
      if (got.nack_seen !== want.nack_seen)
        report_mismatch("nack", {7'b0, got.nack_seen}, {7'b0, want.nack_seen});
      if (got.is_last !== want.is_last)
        report_mismatch("last", {7'b0, got.is_last}, {7'b0, want.is_last});
    endtask
  endclass

  logic       clk;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [6:0] cfg_wr_data = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] in_command = '0;
  logic [7:0] in_tx_byte = '0;
  logic       in_read_not_write = 1'b0;
  logic       in_send_ack = 1'b0;
  logic       in_sda_level = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_scl_release;
  logic       out_sda_release;
  logic       out_sample_now;
  logic [7:0] out_rx_byte;
  logic       out_rx_valid;
  logic       out_nack;
  logic       out_last;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_req = 1'b0;
  int hold_left = 0;
  int useful_items = 0;
  int quiet_cycles = 0;
  phase_scoreboard sb = new();

  i2c_master_byte_sequencer_unit i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Random field values at the field widths
  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(1));
  endfunction

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req) hold_left = HOLD_CYCLES;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Observe both channels and guard against a hung block
  always @(posedge clk) begin
    bus_phase_t got;
    logic moved;
    if (rst_n) begin
      moved = 1'b0;
      if (in_valid && in_stall === 1'b0) begin
        moved = 1'b1;
        if (sb.note_command(in_command, in_tx_byte, in_read_not_write, in_send_ack,
                            in_sda_level) > 0)
          useful_items++;
      end
      if (out_valid === 1'b1 && !out_stall) begin
        moved = 1'b1;
        got = '{out_scl_release, out_sda_release, out_sample_now, out_rx_byte,
                out_rx_valid, out_nack, out_last};
        sb.check_phase(got);
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d phases outstanding",
                 STALL_LIMIT, sb.pending());
        $display("status: fail");
        $finish;
      end
    end
  end

  // Offer one command and hold it until the transfer happens
  task automatic send_cmd(logic [2:0] cmd, logic [7:0] tx, logic rnw, logic ack, logic lvl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_command        <= cmd;
    in_tx_byte        <= tx;
    in_read_not_write <= rnw;
    in_send_ack       <= ack;
    in_sda_level      <= lvl;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  // Drop valid, wait for every expected phase, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_address(logic [6:0] addr);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= addr;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_address(addr);
  endtask

  // Read a byte; a broken read stops short of eight samples
  task automatic read_byte(bit broken);
    int nbits;
    send_cmd(i2cms_pkg::CMD_READ, rand_byte(), rand_bit(), rand_bit(), rand_bit());
    nbits = broken ? $urandom_range(7) : 8;
    repeat (nbits)
      send_cmd(i2cms_pkg::CMD_SAMPLE, rand_byte(), rand_bit(), rand_bit(), rand_bit());
  endtask

  // Well-formed bus transaction with random content, occasionally cut short
  task automatic run_transaction();
    int nops;
    bit broken;
    send_cmd(i2cms_pkg::CMD_START, rand_byte(), rand_bit(), rand_bit(), rand_bit());
    send_cmd(i2cms_pkg::CMD_ADDR, rand_byte(), rand_bit(), rand_bit(), rand_bit());
    send_cmd(i2cms_pkg::CMD_SAMPLE, rand_byte(), rand_bit(), rand_bit(),
             $urandom_range(9) == 0);
    nops = $urandom_range(1, 3);
    repeat (nops) begin
      broken = ($urandom_range(9) == 0);
      if ($urandom_range(1)) begin
        send_cmd(i2cms_pkg::CMD_WRITE, rand_byte(), rand_bit(), rand_bit(), rand_bit());
        if (!broken)
          send_cmd(i2cms_pkg::CMD_SAMPLE, rand_byte(), rand_bit(), rand_bit(),
                   $urandom_range(7) == 0);
      end else begin
        read_byte(broken);
      end
    end
    if ($urandom_range(3) != 0)
      send_cmd(i2cms_pkg::CMD_STOP, rand_byte(), rand_bit(), rand_bit(), rand_bit());
  endtask

  task automatic run_random(int count);
    int goal;
    goal = useful_items + count;
    while (useful_items < goal) begin
      if ($urandom_range(99) < 80)
        run_transaction();
      else
        send_cmd(3'($urandom_range(7)), rand_byte(), rand_bit(), rand_bit(), rand_bit());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: highest address, byte extremes, both acks, pending commands cut off
    write_address(7'h7F);
    send_cmd(i2cms_pkg::CMD_START, 8'h00, 1'b0, 1'b0, 1'b0);
    send_cmd(i2cms_pkg::CMD_ADDR, 8'h00, 1'b1, 1'b0, 1'b0);
    send_cmd(i2cms_pkg::CMD_SAMPLE, 8'h00, 1'b0, 1'b0, 1'b0);
    send_cmd(i2cms_pkg::CMD_READ, 8'h00, 1'b0, 1'b1, 1'b0);
    for (int i = 0; i < 8; i++)
      send_cmd(i2cms_pkg::CMD_SAMPLE, 8'h00, 1'b0, 1'b0, i[0]);
    send_cmd(i2cms_pkg::CMD_WRITE, 8'hFF, 1'b0, 1'b0, 1'b0);
    send_cmd(i2cms_pkg::CMD_START, 8'h00, 1'b0, 1'b0, 1'b0);
    send_cmd(i2cms_pkg::CMD_SAMPLE, 8'h00, 1'b0, 1'b0, 1'b1);
    send_cmd(CMD_SPARE_A, 8'hFF, 1'b1, 1'b1, 1'b1);
    send_cmd(CMD_SPARE_B, 8'h00, 1'b0, 1'b0, 1'b0);
    send_cmd(i2cms_pkg::CMD_WRITE, 8'h00, 1'b1, 1'b1, 1'b1);
    send_cmd(i2cms_pkg::CMD_SAMPLE, 8'h00, 1'b0, 1'b0, 1'b1);
    send_cmd(i2cms_pkg::CMD_READ, 8'h00, 1'b0, 1'b0, 1'b0);
    send_cmd(i2cms_pkg::CMD_SAMPLE, 8'h00, 1'b0, 1'b0, 1'b1);
    send_cmd(i2cms_pkg::CMD_SAMPLE, 8'h00, 1'b0, 1'b0, 1'b1);
    send_cmd(i2cms_pkg::CMD_STOP, 8'h00, 1'b0, 1'b0, 1'b0);
    drain();

    // Lowest address; sender idles lightly, receiver heavily
    write_address(7'h00);
    send_idle_pct = 23;
    recv_idle_pct <= 55;
    run_random(PHASE_ITEMS);
    drain();

    // Random address; heavy sender idling, light receiver idling
    write_address(7'($urandom_range(127)));
    send_idle_pct = 55;
    recv_idle_pct <= 23;
    run_random(PHASE_ITEMS);
    drain();

    // Random address; no idling, with a long receiver hold-off at the start
    write_address(7'($urandom_range(127)));
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    run_random(PHASE_ITEMS);
    drain();
    repeat (20) @(posedge clk);

    $display("covered %0d commands with bus phases, %0d phases checked", useful_items,
             sb.checked);
    $display("received %0d bytes, saw %0d missing acknowledges", sb.bytes_read, sb.nacks);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
